/* rtl/dsce_pkg.sv */
// ----------------------------------------------------------------------------
// dsce_pkg: shared types and constants for the DMX slot change event block
// Holds the command encoding between the front and the back end, the map
// entry modes, the engine state type and the priority encode helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package dsce_pkg;

  localparam int CH_SLOTS   = 512;
  localparam int CH_W       = 9;
  localparam int MARK_WORDS = 16;
  localparam int MARK_BITS  = 32;
  localparam int MW_W       = 4;
  localparam int MB_W       = 5;

  // Map entry modes.
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SINGLE = 2'd1;
  localparam logic [1:0] MODE_COARSE = 2'd2;
  localparam logic [1:0] MODE_FINE   = 2'd3;

  // Input opcodes.
  localparam logic [1:0] OP_MAP  = 2'd0;
  localparam logic [1:0] OP_SLOT = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Result kinds.
  localparam logic [1:0] RES_MAP_OK   = 2'd0;
  localparam logic [1:0] RES_CONFLICT = 2'd1;
  localparam logic [1:0] RES_EVENT    = 2'd2;
  localparam logic [1:0] RES_NONE     = 2'd3;

  typedef enum logic [1:0] {
    CMD_MAP,
    CMD_SLOT,
    CMD_READ,
    CMD_CONFLICT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CH_W-1:0]  ch;
    logic [CH_W-1:0]  pt;
    logic             pair;
    logic [7:0]       val;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [CH_W-1:0]  ch;
    logic [15:0]      value;
    logic             wide;
  } result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SLOT,
    ST_MAP_B,
    ST_MAP_A,
    ST_RD1,
    ST_RD2,
    ST_RD3
  } eng_state_t;

  // Index of the lowest set bit of a summary word.
  function automatic logic [MW_W-1:0] lowest_word(input logic [MARK_WORDS-1:0] v);
    logic [MW_W-1:0] idx;
    idx = '0;
    for (int i = MARK_WORDS - 1; i >= 0; i--) begin
      if (v[i]) idx = MW_W'(i);
    end
    return idx;
  endfunction

  // Index of the lowest set bit of a mark word.
  function automatic logic [MB_W-1:0] lowest_bit(input logic [MARK_BITS-1:0] v);
    logic [MB_W-1:0] idx;
    idx = '0;
    for (int i = MARK_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = MB_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

/* rtl/dsce_ram.sv */
// ----------------------------------------------------------------------------
// dsce_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module dsce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/dsce_front.sv */
// ----------------------------------------------------------------------------
// dsce_front: input side of the DMX slot change event block
// Classifies each input item into a command and holds it in a two-entry
// queue for the back end. Ignored items never enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module dsce_front #(
  parameter int NUM_CHANNELS = 512
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic                  busy,
  input  wire logic [1:0]            in_opcode,
  input  wire logic [8:0]            in_channel_index,
  input  wire logic [8:0]            in_partner_index,
  input  wire logic                  in_is_pair,
  input  wire logic [7:0]            in_slot_value,
  output logic                       q_valid,
  output dsce_pkg::cmd_t             q_cmd,
  input  wire logic                  q_pop
);
  import dsce_pkg::*;

  localparam logic [CH_W:0] NCH = (CH_W+1)'(NUM_CHANNELS);

  cmd_t       ent_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] count_r, count_nxt;
  cmd_t       cls;
  logic       keep, xfer;
  logic       ch_ok, pt_ok;

  // Classify the incoming item.
  always_comb begin
    ch_ok    = {1'b0, in_channel_index} < NCH;
    pt_ok    = {1'b0, in_partner_index} < NCH;
    cls.ch   = in_channel_index;
    cls.pt   = in_partner_index;
    cls.pair = in_is_pair;
    cls.val  = in_slot_value;
    cls.kind = CMD_READ;
    keep     = 1'b0;
    unique case (in_opcode)
      OP_MAP: begin
        keep     = 1'b1;
        cls.kind = (ch_ok && (pt_ok || !in_is_pair)) ? CMD_MAP : CMD_CONFLICT;
      end
      OP_SLOT: begin
        keep     = ch_ok;
        cls.kind = CMD_SLOT;
      end
      OP_READ: begin
        keep     = 1'b1;
        cls.kind = CMD_READ;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full    = busy || (count_r == 2'd2);
  assign xfer    = push && !full;
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = ent_r[rptr_r];

  always_comb begin
    count_nxt = count_r + 2'(xfer && keep) - 2'(q_pop);
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (xfer && keep) wptr_r <= !wptr_r;
      if (q_pop) rptr_r <= !rptr_r;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (xfer && keep) begin
      ent_r[wptr_r] <= cls;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("command queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0) else $error("pop from empty command queue");
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> full) else $error("transfer possible during clearing pass");

endmodule
`default_nettype wire

/* rtl/dsce_back.sv */
// ----------------------------------------------------------------------------
// dsce_back: command engine of the DMX slot change event block
// Runs map, slot and event-read commands against the slot, map and mark
// memories and keeps a one-entry result register toward the output side.
// ----------------------------------------------------------------------------
`default_nettype none
module dsce_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  output logic                 busy,
  input  wire logic            q_valid,
  input  wire dsce_pkg::cmd_t  q_cmd,
  output logic                 q_pop,
  output logic                 empty,
  input  wire logic            pop,
  output dsce_pkg::result_t    res
);
  import dsce_pkg::*;

  eng_state_t st_r, st_nxt;
  logic [CH_W-1:0] clr_r;
  cmd_t            cur_r, cur_nxt;
  logic [MARK_WORDS-1:0] sum_r, sum_nxt;
  logic [MW_W-1:0] w_r, w_nxt;
  logic [CH_W-1:0] p_r, p_nxt, q_r, q_nxt;
  logic [7:0]      pv_r, pv_nxt;
  logic            fine_r, fine_nxt;
  logic            out_valid_r;
  result_t         out_r, res_nxt;
  logic            res_we;

  // Memory ports.
  logic            s_we, m_we, k_we;
  logic [CH_W-1:0] s_waddr, s_raddr, m_waddr, m_raddr;
  logic [7:0]      s_wdata, s_rdata;
  logic [10:0]     m_wdata, m_rdata;
  logic [MW_W-1:0] k_waddr, k_raddr;
  logic [MARK_BITS-1:0] k_wdata, k_rdata;

  dsce_ram #(.WIDTH(8), .DEPTH(CH_SLOTS)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata));
  dsce_ram #(.WIDTH(11), .DEPTH(CH_SLOTS)) u_map (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata));
  dsce_ram #(.WIDTH(MARK_BITS), .DEPTH(MARK_WORDS)) u_mark (
    .clk, .we(k_we), .waddr(k_waddr), .wdata(k_wdata), .raddr(k_raddr), .rdata(k_rdata));

  logic [1:0]      rd_mode;
  logic [CH_W-1:0] rd_part;
  logic            dispatch, sum_any, fine_bad, prim_bad, slot_hit;
  logic [MB_W-1:0] low_b;
  logic [CH_W-1:0] p_found;
  logic [MARK_BITS-1:0] k_clr_p, k_clr_q;

  assign rd_mode  = m_rdata[10:9];
  assign rd_part  = m_rdata[8:0];
  assign sum_any  = |sum_r;
  assign dispatch = q_valid && (q_cmd.kind == CMD_SLOT || !out_valid_r);
  assign fine_bad = (rd_mode != MODE_OFF) && !(rd_mode == MODE_FINE && rd_part == cur_r.ch);
  assign prim_bad = cur_r.pair ?
      ((cur_r.ch == cur_r.pt) ||
       ((rd_mode != MODE_OFF) && !(rd_mode == MODE_COARSE && rd_part == cur_r.pt))) :
      ((rd_mode != MODE_OFF) && !(rd_mode == MODE_SINGLE && rd_part == cur_r.ch));
  assign slot_hit = (rd_mode != MODE_OFF) && (s_rdata != cur_r.val);
  assign low_b    = lowest_bit(k_rdata);
  assign p_found  = {w_r, low_b};
  assign k_clr_p  = k_rdata & ~(MARK_BITS'(1) << low_b);
  assign k_clr_q  = k_rdata & ~(MARK_BITS'(1) << q_r[MB_W-1:0]);
  assign busy     = (st_r == ST_CLEAR);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR: if (clr_r == CH_W'(CH_SLOTS - 1)) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (dispatch) begin
          unique case (q_cmd.kind)
            CMD_SLOT:     st_nxt = ST_SLOT;
            CMD_MAP:      st_nxt = q_cmd.pair ? ST_MAP_B : ST_MAP_A;
            CMD_READ:     st_nxt = sum_any ? ST_RD1 : ST_IDLE;
            CMD_CONFLICT: st_nxt = ST_IDLE;
            default:      st_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SLOT:  st_nxt = ST_IDLE;
      ST_MAP_B: st_nxt = fine_bad ? ST_IDLE : ST_MAP_A;
      ST_MAP_A: st_nxt = ST_IDLE;
      ST_RD1:   st_nxt = ST_RD2;
      ST_RD2:   st_nxt = (rd_mode == MODE_COARSE || rd_mode == MODE_FINE) ? ST_RD3 : ST_IDLE;
      ST_RD3:   st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  // Memory accesses, results and working registers.
  always_comb begin
    q_pop    = 1'b0;
    cur_nxt  = cur_r;
    sum_nxt  = sum_r;
    w_nxt    = w_r;
    p_nxt    = p_r;
    q_nxt    = q_r;
    pv_nxt   = pv_r;
    fine_nxt = fine_r;
    s_we = 1'b0; s_waddr = cur_r.ch; s_wdata = cur_r.val; s_raddr = q_cmd.ch;
    m_we = 1'b0; m_waddr = cur_r.ch; m_wdata = '0;        m_raddr = q_cmd.ch;
    k_we = 1'b0; k_waddr = w_r;      k_wdata = k_clr_p;   k_raddr = q_cmd.ch[CH_W-1:MB_W];
    res_we  = 1'b0;
    res_nxt = '{kind: RES_MAP_OK, ch: '0, value: '0, wide: 1'b0};
    unique case (st_r)
      ST_CLEAR: begin
        s_we = 1'b1; s_waddr = clr_r; s_wdata = '0;
        m_we = 1'b1; m_waddr = clr_r; m_wdata = '0;
        k_we = 1'b1; k_waddr = clr_r[MW_W-1:0]; k_wdata = '0;
      end
      ST_IDLE: begin
        if (dispatch) begin
          q_pop   = 1'b1;
          cur_nxt = q_cmd;
          w_nxt   = lowest_word(sum_r);
          if (q_cmd.kind == CMD_MAP && q_cmd.pair) m_raddr = q_cmd.pt;
          if (q_cmd.kind == CMD_READ) k_raddr = lowest_word(sum_r);
          if (q_cmd.kind == CMD_CONFLICT) begin
            res_we       = 1'b1;
            res_nxt.kind = RES_CONFLICT;
          end
          if (q_cmd.kind == CMD_READ && !sum_any) begin
            res_we       = 1'b1;
            res_nxt.kind = RES_NONE;
          end
        end
      end
      ST_SLOT: begin
        // Store a changed byte of an active channel and mark it.
        if (slot_hit) begin
          s_we    = 1'b1;
          k_we    = 1'b1;
          k_waddr = cur_r.ch[CH_W-1:MB_W];
          k_wdata = k_rdata | (MARK_BITS'(1) << cur_r.ch[MB_W-1:0]);
          sum_nxt[cur_r.ch[CH_W-1:MB_W]] = 1'b1;
        end
      end
      ST_MAP_B: begin
        // Fine channel check; write it and fetch the coarse entry.
        if (fine_bad) begin
          res_we       = 1'b1;
          res_nxt.kind = RES_CONFLICT;
        end else begin
          m_we    = 1'b1;
          m_waddr = cur_r.pt;
          m_wdata = {MODE_FINE, cur_r.ch};
          m_raddr = cur_r.ch;
        end
      end
      ST_MAP_A: begin
        res_we = 1'b1;
        if (prim_bad) begin
          res_nxt.kind = RES_CONFLICT;
        end else begin
          m_we    = 1'b1;
          m_wdata = cur_r.pair ? {MODE_COARSE, cur_r.pt} : {MODE_SINGLE, cur_r.ch};
        end
      end
      ST_RD1: begin
        // Clear the lowest mark and fetch its entry.
        k_we   = 1'b1;
        sum_nxt[w_r] = |k_clr_p;
        p_nxt   = p_found;
        s_raddr = p_found;
        m_raddr = p_found;
      end
      ST_RD2: begin
        pv_nxt   = s_rdata;
        q_nxt    = rd_part;
        fine_nxt = (rd_mode == MODE_FINE);
        s_raddr  = rd_part;
        k_raddr  = rd_part[CH_W-1:MB_W];
        if (!(rd_mode == MODE_COARSE || rd_mode == MODE_FINE)) begin
          res_we  = 1'b1;
          res_nxt = '{kind: RES_EVENT, ch: p_r, value: {8'd0, s_rdata}, wide: 1'b0};
        end
      end
      ST_RD3: begin
        // Clear the partner's mark and report the pair.
        k_we    = 1'b1;
        k_waddr = q_r[CH_W-1:MB_W];
        k_wdata = k_clr_q;
        sum_nxt[q_r[CH_W-1:MB_W]] = |k_clr_q;
        res_we  = 1'b1;
        res_nxt.kind = RES_EVENT;
        res_nxt.wide = 1'b1;
        res_nxt.ch    = fine_r ? q_r : p_r;
        res_nxt.value = fine_r ? {s_rdata, pv_r} : {pv_r, s_rdata};
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      sum_r <= sum_nxt;
      if (st_r == ST_CLEAR) clr_r <= clr_r + CH_W'(1);
      if (res_we) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    w_r    <= w_nxt;
    p_r    <= p_nxt;
    q_r    <= q_nxt;
    pv_r   <= pv_nxt;
    fine_r <= fine_nxt;
    if (res_we) out_r <= res_nxt;
  end

  assign empty = !out_valid_r;
  assign res   = out_r;

  a_res_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |-> !out_valid_r) else $error("result register overwritten");
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> st_r == ST_CLEAR) else $error("no clearing pass after reset");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !q_pop) else $error("command taken during clearing pass");

endmodule
`default_nettype wire

/* rtl/dmx_slot_change_events.sv */
// ----------------------------------------------------------------------------
// dmx_slot_change_events: DMX universe store with channel map and change events
//
//   channel  direction  handshake           payload
//   input    in         push / full         in_opcode .. in_slot_value
//   result   out        empty / pop         out_result_kind .. out_event_wide
//
// A slot item reads, compares and writes the slot memory. A map item with an
// index out of range is answered as a conflict. The slot, map and mark memories
// each have one read port, so a map item steps through ST_MAP_B (pairs) and
// ST_MAP_A, an event read through ST_RD1, ST_RD2 and, for a pair, ST_RD3. After
// reset a clearing pass runs over all memories; full stays high meanwhile.
// A two-entry command queue lets input transfers continue while a result
// waits; slot items proceed even while the result is not taken.
// ----------------------------------------------------------------------------
`default_nettype none
module dmx_slot_change_events #(
  parameter int NUM_CHANNELS = 512
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] in_opcode,
  input  wire logic [8:0] in_channel_index,
  input  wire logic [8:0] in_partner_index,
  input  wire logic       in_is_pair,
  input  wire logic [7:0] in_slot_value,
  output logic            empty,
  input  wire logic       pop,
  output logic [1:0]      out_result_kind,
  output logic [8:0]      out_event_channel,
  output logic [15:0]     out_event_value,
  output logic            out_event_wide
);
  import dsce_pkg::*;

  logic    busy, q_valid, q_pop;
  cmd_t    q_cmd;
  result_t res;

  // Front end: classify and queue.
  dsce_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .clk, .rst_n, .push, .full, .busy,
    .in_opcode, .in_channel_index, .in_partner_index, .in_is_pair, .in_slot_value,
    .q_valid, .q_cmd, .q_pop
  );

  // Back end: command engine and result register.
  dsce_back u_back (
    .clk, .rst_n, .busy, .q_valid, .q_cmd, .q_pop, .empty, .pop, .res
  );

  assign out_result_kind   = res.kind;
  assign out_event_channel = res.ch;
  assign out_event_value   = res.value;
  assign out_event_wide    = res.wide;

endmodule
`default_nettype wire
